// ===== sv/b64v_pkg.sv =====
package b64v_pkg;

    localparam logic [7:0]  PAD_CHAR    = 8'h3d;
    localparam logic [15:0] LIMIT_RESET = 16'hffff;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;
    localparam int unsigned Q_CW    = 3;

    typedef enum logic [1:0] {
        STATUS_DATA = 2'd0,
        STATUS_OK   = 2'd1,
        STATUS_ERR  = 2'd2
    } status_t;

    // one queued job: a decoded group and/or the end-of-message marker
    typedef struct packed {
        logic [23:0] quad;
        logic [2:0]  present;
        logic        done;
        logic        err;
    } grp_cmd_t;

    // {valid, sextet}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = {1'b1, 6'(c - 8'h41)};
        end
        else if (c >= 8'h61 && c <= 8'h7a)
        begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == 8'h26)
        begin
            r = {1'b1, 6'd62};
        end
        else if (c == 8'h24)
        begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

// ===== sv/b64v_char_if.sv =====
interface b64v_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       final_char;

    modport source (output valid, output character, output final_char, input ready);
    modport sink   (input valid, input character, input final_char, output ready);
endinterface

// ===== sv/b64v_res_if.sv =====
interface b64v_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output data_byte, output status, output last, input ready);
    modport sink   (input valid, input data_byte, input status, input last, output ready);
endinterface

// ===== sv/b64v_front.sv =====
module b64v_front (
    input  logic               clk,
    input  logic               rst_n,
    b64v_char_if.sink          in_chan,
    input  logic               q_full,
    output logic               q_push,
    output b64v_pkg::grp_cmd_t q_cmd
);
    import b64v_pkg::*;

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  pad_reg, pad_next;
    logic        err_reg, err_next;

    logic [6:0]  lookup;
    logic        is_pad;
    logic [5:0]  v;
    logic [1:0]  pad_upd;
    logic [1:0]  pad_for;
    logic [17:0] acc_sh;
    logic        emit;
    logic        accept;

    assign in_chan.ready = !q_full;
    assign accept        = in_chan.valid && !q_full;

    always_comb
    begin
        lookup   = sextet_of(in_chan.character);
        is_pad   = (in_chan.character == PAD_CHAR);
        v        = is_pad ? 6'd0 : lookup[5:0];
        pad_upd  = pad_reg | {is_pad && (pos_reg == 2'd3), is_pad && (pos_reg == 2'd2)};
        acc_sh   = {acc_reg[11:0], v};
        acc_next = acc_reg;
        pos_next = pos_reg;
        pad_next = pad_reg;
        err_next = err_reg;
        emit     = 1'b0;
        pad_for  = 2'b00;
        q_cmd    = '0;

        if (!err_reg)
        begin
            if (!lookup[6] && !(is_pad && pos_reg[1]))
            begin
                err_next = 1'b1;
                acc_next = '0;
                pos_next = '0;
                pad_next = '0;
            end
            else if (pos_reg == 2'd3)
            begin
                emit       = 1'b1;
                q_cmd.quad = {acc_reg, v};
                pad_for    = pad_upd;
                acc_next   = '0;
                pos_next   = '0;
                pad_next   = '0;
            end
            else
            begin
                acc_next = acc_sh;
                pos_next = pos_reg + 2'd1;
                pad_next = pad_upd;
                if (in_chan.final_char)
                begin
                    // short final group: missing sextets read as zero
                    emit    = 1'b1;
                    pad_for = pad_upd;
                    case (pos_reg)
                        2'd0:    q_cmd.quad = {v, 18'd0};
                        2'd1:    q_cmd.quad = {acc_sh[11:0], 12'd0};
                        default: q_cmd.quad = {acc_sh, 6'd0};
                    endcase
                end
            end
        end

        q_cmd.present = emit ? {~pad_for[1], ~pad_for[0], 1'b1} : 3'b000;

        if (in_chan.final_char)
        begin
            q_cmd.done = 1'b1;
            q_cmd.err  = err_next;
            acc_next   = '0;
            pos_next   = '0;
            pad_next   = '0;
            err_next   = 1'b0;
        end

        q_push = accept && (emit || in_chan.final_char);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
            pad_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            pad_reg <= pad_next;
            err_reg <= err_next;
        end
    end
endmodule

// ===== sv/b64v_queue.sv =====
module b64v_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64v_pkg::grp_cmd_t push_cmd,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output b64v_pkg::grp_cmd_t head_cmd
);
    import b64v_pkg::*;

    grp_cmd_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_reg, wr_next;
    logic [Q_AW-1:0]   rd_reg, rd_next;
    logic [Q_CW-1:0]   cnt_reg, cnt_next;
    logic              do_pop;

    assign full       = (cnt_reg == Q_CW'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = slot_reg[rd_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + Q_CW'(push) - Q_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ===== sv/b64v_back.sv =====
module b64v_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               head_valid,
    input  b64v_pkg::grp_cmd_t head_cmd,
    output logic               pop,
    b64v_res_if.source         out_chan
);
    import b64v_pkg::*;

    logic [15:0] limit_reg;
    logic [15:0] cnt_reg, cnt_next;
    logic [2:0]  used_reg, used_next;
    logic        ov_reg, ov_next;
    logic [7:0]  data_reg, data_next;
    status_t     stat_reg, stat_next;
    logic        last_reg, last_next;

    logic [2:0]  pend;
    logic [2:0]  pick;
    logic [7:0]  pick_byte;
    logic        out_free;
    logic        load;

    assign out_chan.valid     = ov_reg;
    assign out_chan.data_byte = data_reg;
    assign out_chan.status    = stat_reg;
    assign out_chan.last      = last_reg;

    always_comb
    begin
        pend     = head_cmd.present & ~used_reg;
        out_free = !ov_reg || out_chan.ready;

        if (pend[0])
        begin
            pick      = 3'b001;
            pick_byte = head_cmd.quad[23:16];
        end
        else if (pend[1])
        begin
            pick      = 3'b010;
            pick_byte = head_cmd.quad[15:8];
        end
        else
        begin
            pick      = 3'b100;
            pick_byte = head_cmd.quad[7:0];
        end

        cnt_next  = cnt_reg;
        used_next = used_reg;
        data_next = data_reg;
        stat_next = stat_reg;
        last_next = last_reg;
        load      = 1'b0;
        pop       = 1'b0;

        if (head_valid && out_free)
        begin
            if ((cnt_reg < limit_reg) && (pend != 3'b000))
            begin
                load      = 1'b1;
                data_next = pick_byte;
                stat_next = STATUS_DATA;
                last_next = 1'b0;
                cnt_next  = cnt_reg + 16'd1;
                used_next = used_reg | pick;
                if (((pend & ~pick) == 3'b000) && !head_cmd.done)
                begin
                    pop       = 1'b1;
                    used_next = '0;
                end
            end
            else if (head_cmd.done)
            begin
                load      = 1'b1;
                data_next = 8'd0;
                stat_next = head_cmd.err ? STATUS_ERR : STATUS_OK;
                last_next = 1'b1;
                cnt_next  = '0;
                pop       = 1'b1;
                used_next = '0;
            end
            else
            begin
                // over the limit: group dropped
                pop       = 1'b1;
                used_next = '0;
            end
        end

        ov_next = out_free ? load : ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            cnt_reg   <= '0;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            cnt_reg  <= cnt_next;
            used_reg <= used_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        stat_reg <= stat_next;
        last_reg <= last_next;
    end
endmodule

// ===== sv/base64_variant_decoder.sv =====
// channel   | dir | word
// in_chan   | in  | character[7:0], final_char
// out_chan  | out | data_byte[7:0], status[1:0], last
// cfg_wr_*  | in  | byte_limit[15:0], written when cfg_wr_en is high
//
// One character is taken each cycle while the four-entry group queue has room.
// The result stage sends one word a cycle unless out_chan stalls; a group gives
// one word per byte, a group dropped over the limit none, and a message a done word.
// Output stalls back up through the queue to in_chan.ready.
// Reset clears group state, counters and queue; byte_limit returns to 65535.
module base64_variant_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    b64v_char_if.sink   in_chan,
    b64v_res_if.source  out_chan
);
    import b64v_pkg::*;

    logic     q_full;
    logic     q_push;
    grp_cmd_t q_cmd;
    logic     q_pop;
    logic     head_valid;
    grp_cmd_t head_cmd;

    b64v_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_chan (in_chan),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    b64v_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    b64v_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (q_pop),
        .out_chan    (out_chan)
    );
endmodule

// ===== verif/tb_base64_variant_decoder.sv =====
`timescale 1ns / 100ps

module tb_base64_variant_decoder;
    import b64v_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] data_byte;
        status_t    status;
        logic       last;
    } result_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        logic [7:0] byte_v;
        status_t    st;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    b64v_char_if char_chan ();
    b64v_res_if  res_chan ();

    base64_variant_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_chan     (char_chan),
        .out_chan    (res_chan)
    );

    // decoder state as predicted
    logic [15:0]  limit_now  = 16'hffff;
    logic [17:0]  sextets    = '0;
    logic [1:0]   grp_pos    = '0;
    logic [1:0]   pad_bits   = '0;
    logic [15:0]  bytes_out  = '0;
    logic         msg_err    = 1'b0;

    result_word_t due_words[$];
    int           fails      = 0;
    int           item_count = 0;
    int           cycle_count = 0;
    bit           quiet      = 1'b0;
    logic         drv_typed;
    result_word_t drv_word;
    script_row_t  script[25];

    function automatic int sextet_code(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return int'(c) - int'("A");
        end
        if (c >= "a" && c <= "z")
        begin
            return int'(c) - int'("a") + 26;
        end
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0") + 52;
        end
        if (c == "&")
        begin
            return 62;
        end
        if (c == "$")
        begin
            return 63;
        end
        return -1;
    endfunction

    function automatic logic [7:0] alpha_char(input int v);
        if (v < 26)
        begin
            return 8'(int'("A") + v);
        end
        if (v < 52)
        begin
            return 8'(int'("a") + v - 26);
        end
        if (v < 62)
        begin
            return 8'(int'("0") + v - 52);
        end
        return (v == 62) ? 8'h26 : 8'h24;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        if (bytes_out < limit_now)
        begin
            due_words.push_back('{b, STATUS_DATA, 1'b0});
            bytes_out++;
        end
    endfunction

    function automatic void emit_group(input logic [23:0] quad);
        push_byte(quad[23:16]);
        if (!pad_bits[0])
        begin
            push_byte(quad[15:8]);
        end
        if (!pad_bits[1])
        begin
            push_byte(quad[7:0]);
        end
        sextets  = '0;
        grp_pos  = '0;
        pad_bits = '0;
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic fin);
        int          code;
        logic        pad;
        logic [1:0]  pos;
        logic [5:0]  v;
        logic [23:0] quad;
        if (!msg_err)
        begin
            code = sextet_code(c);
            pad  = (c == PAD_CHAR);
            pos  = grp_pos;
            if (code < 0 && !(pad && pos >= 2))
            begin
                msg_err  = 1'b1;
                sextets  = '0;
                grp_pos  = '0;
                pad_bits = '0;
            end
            else
            begin
                v = pad ? 6'd0 : 6'(code);
                if (pad && pos == 2)
                begin
                    pad_bits[0] = 1'b1;
                end
                if (pad && pos == 3)
                begin
                    pad_bits[1] = 1'b1;
                end
                if (pos == 3)
                begin
                    emit_group({sextets, v});
                end
                else
                begin
                    sextets = {sextets[11:0], v};
                    grp_pos = pos + 2'd1;
                    if (fin)
                    begin
                        // missing sextets of a short final group read as zero
                        quad = {6'd0, sextets} << (6 * (3 - pos));
                        emit_group(quad);
                    end
                end
            end
        end
        if (fin)
        begin
            due_words.push_back('{8'd0, msg_err ? STATUS_ERR : STATUS_OK, 1'b1});
            sextets   = '0;
            grp_pos   = '0;
            pad_bits  = '0;
            bytes_out = '0;
            msg_err   = 1'b0;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // predict before checking, so a same-edge result is still matched
    always @(posedge clk)
    begin : monitor
        int           n;
        result_word_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                limit_now = cfg_wr_data;
            end
            if (char_chan.valid && char_chan.ready)
            begin
                n = due_words.size();
                decode_char(char_chan.character, char_chan.final_char);
                if (drv_typed)
                begin
                    while (due_words.size() > n)
                    begin
                        void'(due_words.pop_back());
                    end
                    due_words.push_back(drv_word);
                end
            end
            if (res_chan.valid && res_chan.ready)
            begin
                if (due_words.size() == 0)
                begin
                    $error("unexpected word: data_byte %02h status %0d last %0b",
                           res_chan.data_byte, res_chan.status, res_chan.last);
                    fails++;
                end
                else
                begin
                    want = due_words.pop_front();
                    if (res_chan.data_byte !== want.data_byte)
                    begin
                        $error("data_byte: expected %02h, got %02h",
                               want.data_byte, res_chan.data_byte);
                        fails++;
                    end
                    if (res_chan.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, res_chan.status);
                        fails++;
                    end
                    if (res_chan.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, res_chan.last);
                        fails++;
                    end
                end
            end
        end
    end

    initial
    begin : sink_side
        int hold;
        hold = 0;
        res_chan.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else if (quiet || $urandom_range(0, 3) != 0)
            begin
                res_chan.ready = 1'b1;
                hold = $urandom_range(0, 8);
            end
            else
            begin
                res_chan.ready = 1'b0;
                hold = pick_gap();
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the character is taken
    task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
                             input result_word_t word);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            char_chan.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_chan.valid      = 1'b1;
        char_chan.character  = c;
        char_chan.final_char = fin;
        drv_typed            = typed;
        drv_word             = word;
        @(posedge clk);
        while (!char_chan.ready)
        begin
            @(posedge clk);
        end
        item_count++;
        @(negedge clk);
    endtask

    task automatic drain_words();
        char_chan.valid = 1'b0;
        drv_typed       = 1'b0;
        while (due_words.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic settle();
        drain_words();
        repeat (12) @(negedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        settle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic send_message();
        logic [7:0] msg[$];
        logic [7:0] c;
        int         groups;
        int         tail;
        int         r;
        int         r2;
        int         k;
        int         j;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            // noise
            k = $urandom_range(1, 6);
            repeat (k) msg.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
            tail   = $urandom_range(0, 3);
            if (groups == 0 && tail == 0)
            begin
                tail = $urandom_range(1, 3);
            end
            for (k = 0; k < groups; k++)
            begin
                for (j = 0; j < 4; j++)
                begin
                    msg.push_back(alpha_char($urandom_range(0, 63)));
                end
                r2 = $urandom_range(0, 19);
                if (r2 == 0 || r2 == 3)
                begin
                    msg[msg.size() - 2] = PAD_CHAR;
                end
                if (r2 == 1 || r2 == 2 || r2 == 3)
                begin
                    msg[msg.size() - 1] = PAD_CHAR;
                end
            end
            for (k = 0; k < tail; k++)
            begin
                msg.push_back(alpha_char($urandom_range(0, 63)));
            end
            if (tail == 3 && $urandom_range(0, 3) == 0)
            begin
                msg[msg.size() - 1] = PAD_CHAR;
            end
            if (r < 30)
            begin
                c = 8'($urandom_range(0, 255));
                while (sextet_code(c) >= 0)
                begin
                    c = 8'($urandom_range(0, 255));
                end
                msg[$urandom_range(0, msg.size() - 1)] = c;
            end
        end
        for (k = 0; k < msg.size(); k++)
        begin
            send_char(msg[k], k == msg.size() - 1, 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        logic [15:0] limits[8];
        int          phase_end;
        int          p;
        int          m;
        int          i;

        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        char_chan.valid      = 1'b0;
        char_chan.character  = '0;
        char_chan.final_char = 1'b0;
        drv_typed            = 1'b0;
        drv_word             = '0;

        script = '{
            '{"A", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"A", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"A", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"A", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"$", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"$", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"$", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"=", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"Q", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"Q", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"=", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"=", 1'b0, 1'b1, 8'h41, STATUS_DATA},
            '{"a", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"b", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"=", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"c", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"M", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"Z", 1'b1, 1'b0, 8'h00, STATUS_DATA},
            '{8'hff, 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"A", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"=", 1'b1, 1'b1, 8'h00, STATUS_ERR},
            '{"A", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"B", 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{8'h00, 1'b0, 1'b0, 8'h00, STATUS_DATA},
            '{"x", 1'b1, 1'b1, 8'h00, STATUS_ERR}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < 25; i++)
        begin
            send_char(script[i].ch, script[i].fin, script[i].typed,
                      '{script[i].byte_v, script[i].st, script[i].st != STATUS_DATA});
        end

        limits[0] = 16'd0;
        limits[1] = 16'd1;
        limits[2] = 16'd2;
        limits[3] = 16'($urandom_range(3, 9));
        limits[4] = 16'hffff;
        limits[5] = 16'($urandom_range(0, 65535));
        limits[6] = 16'($urandom_range(0, 20));
        limits[7] = 16'hffff;

        phase_end = item_count;
        for (p = 0; p < 8; p++)
        begin
            write_limit(limits[p]);
            quiet     = (p == 3);
            phase_end += 38;
            m = 0;
            while (item_count < phase_end)
            begin
                send_message();
                m++;
                if (p == 5 && m == 2)
                begin
                    drain_words();
                end
            end
        end
        quiet = 1'b0;

        settle();
        repeat (20) @(negedge clk);
        if (due_words.size() != 0)
        begin
            $error("words still due at end: %0d", due_words.size());
            fails++;
        end
        if (fails == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
